/* src/mbps_pkg.sv */
// shared constants and types for the masked byte pattern scan core
package mbps_pkg;

    // scan geometry
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int COUNT_BITS        = 32;
    localparam int PATTERN_SLOTS     = 16;
    localparam int IDX_W             = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);

    // register and field widths
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int CARE_W    = 16;
    localparam int CFG_LEN_W = 5;
    localparam int PAT_W     = 8 * PATTERN_SLOTS;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_BASE_ADDRESS   = 3'd4
    } cfg_index_t;

    // byte history, entry 0 newest
    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_t;

    // one pending result word
    typedef struct packed {
        logic                  found;
        logic [COUNT_BITS-1:0] offset;
    } scan_result_t;

endpackage

/* src/mbps_window_match.sv */
// parallel masked compare of the byte window against the pattern
module mbps_window_match import mbps_pkg::*; (
    input  window_t            window,
    input  logic [PAT_W-1:0]   pattern,
    input  logic [CARE_W-1:0]  care_mask,
    input  logic [LEN_W-1:0]   used_len,
    output logic               hit
);

    // pattern position j lines up with window entry used_len-1-j
    always_comb begin
        logic [LEN_W-1:0] len_m1;
        logic [LEN_W-1:0] idx;
        logic [7:0]       sel_byte;
        hit    = 1'b1;
        len_m1 = used_len - LEN_W'(1);
        idx    = '0;
        sel_byte = '0;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            if (LEN_W'(j) <= len_m1) begin
                idx      = len_m1 - LEN_W'(j);
                sel_byte = window[idx[IDX_W-1:0]];
                // positions past the pattern slots are wildcards
                if (j < PATTERN_SLOTS && care_mask[j % CARE_W] &&
                    sel_byte != pattern[(j % PATTERN_SLOTS)*8 +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
    end

endmodule

/* src/mbps_result_stage.sv */
// pending result register, address add and output register
module mbps_result_stage import mbps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  scan_result_t       result,
    input  logic [ADDR_W-1:0]  base_address,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_match_found,
    output logic [ADDR_W-1:0]  m_match_address
);

    logic                pend_valid_reg, pend_valid_next;
    scan_result_t        pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic                out_free;

    // output slot frees when empty or taken
    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !pend_valid_reg || out_free;

    // pending word moves on when the output slot is free
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_addr_next   = out_addr_reg;
        if (out_free) begin
            out_valid_next = pend_valid_reg;
            out_found_next = pend_reg.found;
            out_addr_next  = pend_reg.found ?
                             base_address + ADDR_W'(pend_reg.offset) : '0;
        end
        if (in_ready) begin
            pend_valid_next = push;
            pend_next       = result;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pend_reg      <= pend_next;
        out_found_reg <= out_found_next;
        out_addr_reg  <= out_addr_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_match_found   = out_found_reg;
    assign m_match_address = out_addr_reg;

endmodule

/* src/masked_byte_pattern_scan_core.sv */
// top level of the masked byte pattern scan core
//
// Scans a memory region one byte word at a time on the s_ channel
// (s_data_byte, s_last_byte marks the final byte) for the first place where
// the configured pattern matches; care_mask bits that are clear are wildcards.
// The m_ channel carries at most one word per region: match_found with the
// address base_address plus match offset, or not-found with address 0 at the
// last byte. Bytes after a match are consumed and dropped.
// Throughput is one byte per cycle while s_ready is high: the window shift, the
// 16-lane compare and the byte counter update all settle in the accept cycle. A
// result passes through a pending register, then the output register holding
// the address add, before it shows on m_valid.
// When the receiver stalls, one result waits in the output register and one
// in the pending register; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) clears the window, byte count, match flag,
// both result slots and the configuration registers (pattern_length to 1).
// Configuration writes through cfg_wr_en/cfg_index/cfg_wdata take effect
// from the next byte and are meant for idle periods between regions.
module masked_byte_pattern_scan_core import mbps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_last_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_match_found,
    output logic [ADDR_W-1:0]     m_match_address
);

    logic [63:0]            pattern_low_reg;
    logic [63:0]            pattern_high_reg;
    logic [CARE_W-1:0]      care_mask_reg;
    logic [CFG_LEN_W-1:0]   pattern_length_reg;
    logic [ADDR_W-1:0]      base_address_reg;

    window_t                window_reg, window_next;
    logic [COUNT_BITS-1:0]  seen_reg, seen_next;
    logic                   matched_reg, matched_next;

    window_t                window_shift;
    logic [COUNT_BITS-1:0]  seen_inc;
    logic [LEN_W-1:0]       used_len;
    logic                   accept;
    logic                   active;
    logic                   lane_hit;
    logic                   hit;
    logic                   matched_after;
    logic                   push;
    logic                   in_ready;
    scan_result_t           result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= CFG_LEN_W'(1);
            base_address_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                CFG_CARE_MASK:      care_mask_reg      <= cfg_wdata[CARE_W-1:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[CFG_LEN_W-1:0];
                CFG_BASE_ADDRESS:   base_address_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // clamp the length to 1..MAX_PATTERN_BYTES
    always_comb begin
        if (pattern_length_reg == '0) begin
            used_len = LEN_W'(1);
        end else if (int'(pattern_length_reg) > MAX_PATTERN_BYTES) begin
            used_len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            used_len = LEN_W'(pattern_length_reg);
        end
    end

    // window with the incoming byte shifted in
    always_comb begin
        window_shift[0] = s_data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            window_shift[k] = window_reg[k-1];
        end
    end

    mbps_window_match u_match (
        .window    (window_shift),
        .pattern   ({pattern_high_reg, pattern_low_reg}),
        .care_mask (care_mask_reg),
        .used_len  (used_len),
        .hit       (lane_hit)
    );

    // scan decision for the byte at the input
    assign accept        = s_valid && s_ready;
    assign active        = !matched_reg && (seen_reg != '1);
    assign seen_inc      = seen_reg + COUNT_BITS'(1);
    assign hit           = active && (seen_inc >= COUNT_BITS'(used_len)) && lane_hit;
    assign matched_after = matched_reg || hit;
    assign push          = accept && (hit || (s_last_byte && !matched_after));
    assign result.found  = hit;
    assign result.offset = seen_inc - COUNT_BITS'(used_len);

    // region state update, cleared after the last byte
    always_comb begin
        window_next  = window_reg;
        seen_next    = seen_reg;
        matched_next = matched_reg;
        if (accept) begin
            if (s_last_byte) begin
                window_next  = '0;
                seen_next    = '0;
                matched_next = 1'b0;
            end else if (active) begin
                window_next  = window_shift;
                seen_next    = seen_inc;
                matched_next = matched_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            seen_reg    <= '0;
            matched_reg <= 1'b0;
        end else begin
            window_reg  <= window_next;
            seen_reg    <= seen_next;
            matched_reg <= matched_next;
        end
    end

    mbps_result_stage u_result (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .result          (result),
        .base_address    (base_address_reg),
        .in_ready        (in_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_found   (m_match_found),
        .m_match_address (m_match_address)
    );

    assign s_ready = in_ready;

endmodule
